// ===== rtl/pfra_pkg.sv =====
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared constants, types and command/status bundles for the page frame
// reference count allocator.
// ----------------------------------------------------------------------------
package pfra_pkg;

    // Geometry of the count store
    localparam int NUM_FRAMES = 32768;
    localparam int COUNT_BITS = 8;
    localparam int LANES      = 16;                  // counts per store row
    localparam int ROWS       = NUM_FRAMES / LANES;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int LANE_W     = $clog2(LANES);
    localparam int FA_W       = ROW_W + LANE_W;      // frame address width
    localparam int ROW_DATA_W = LANES * COUNT_BITS;

    // Item field widths
    localparam int FUNC_W   = 3;
    localparam int FRAME_W  = 15;
    localparam int STATUS_W = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int RSV_FIRST_W = 15;
    localparam int RSV_END_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RSV_FIRST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_END   = 1'd1;

    localparam logic [RSV_FIRST_W-1:0] RSV_FIRST_RST = 15'd512;
    localparam logic [RSV_END_W-1:0]   RSV_END_RST   = 16'd768;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SHARE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_INIT  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FREE_FREE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHARE_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [LANE_W-1:0]     lane_t;
    typedef logic [FA_W-1:0]       frame_addr_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [ROW_DATA_W-1:0] row_data_t;

    localparam cnt_t CNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_INIT,    // clearing pass after reset
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_SWEEP,
        ST_RESP
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;       // latch item, issue read of its row
        logic scan_start;   // point scan at the top row
        logic scan_step;    // issue one row read, check the previous one
        logic sweep_start;  // point sweep at row zero
        logic sweep_step;   // write one row of the init pattern
        logic sweep_rst;    // sweep uses the reset range
        logic rmw_eval;     // evaluate free/share/query, write back
        logic out_load;     // move result into the output register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic sweep_last;
        logic out_busy;
    } sts_t;

endpackage

// ===== rtl/pfra_ram.sv =====
// ----------------------------------------------------------------------------
// pfra_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pfra_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfra_ctrl
// Sequencer: clearing pass, item accept, read-modify-write, allocate scan,
// initialize sweep and result hand-off.
// ----------------------------------------------------------------------------
module pfra_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic [pfra_pkg::FUNC_W-1:0] s_func,
    output logic                        s_ready,
    input  pfra_pkg::sts_t              sts,
    output pfra_pkg::cmd_t              cmd
);

    pfra_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfra_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            pfra_pkg::ST_INIT: begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_rst  = 1'b1;
                if (sts.sweep_last) begin
                    state_next = pfra_pkg::ST_IDLE;
                end
            end
            pfra_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    unique case (s_func)
                        pfra_pkg::FUNC_ALLOC: begin
                            cmd.scan_start = 1'b1;
                            state_next     = pfra_pkg::ST_SCAN;
                        end
                        pfra_pkg::FUNC_FREE,
                        pfra_pkg::FUNC_SHARE,
                        pfra_pkg::FUNC_QUERY: begin
                            state_next = pfra_pkg::ST_RMW;
                        end
                        pfra_pkg::FUNC_INIT: begin
                            cmd.sweep_start = 1'b1;
                            state_next      = pfra_pkg::ST_SWEEP;
                        end
                        default: begin
                            state_next = pfra_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            pfra_pkg::ST_RMW: begin
                cmd.rmw_eval = 1'b1;
                state_next   = pfra_pkg::ST_RESP;
            end
            pfra_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = pfra_pkg::ST_RESP;
                end
            end
            pfra_pkg::ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = pfra_pkg::ST_RESP;
                end
            end
            pfra_pkg::ST_RESP: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = pfra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfra_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pfra_datapath.sv =====
// ----------------------------------------------------------------------------
// pfra_datapath
// Config registers, item registers, count-row evaluation, scan and sweep
// pointers, store port muxing and the output register.
// ----------------------------------------------------------------------------
module pfra_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [pfra_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [pfra_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // input item
    input  logic [pfra_pkg::FUNC_W-1:0]     s_func,
    input  logic [pfra_pkg::FRAME_W-1:0]    s_frame_index,
    // control
    input  pfra_pkg::cmd_t                  cmd,
    output pfra_pkg::sts_t                  sts,
    // count store
    output logic                            ram_wr_en,
    output pfra_pkg::row_t                  ram_wr_addr,
    output pfra_pkg::row_data_t             ram_wr_data,
    output logic                            ram_rd_en,
    output pfra_pkg::row_t                  ram_rd_addr,
    input  pfra_pkg::row_data_t             ram_rd_data,
    // result
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pfra_pkg::FRAME_W-1:0]    m_result_frame,
    output logic [pfra_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_is_shared
);

    logic [pfra_pkg::RSV_FIRST_W-1:0] rsv_first_reg;
    logic [pfra_pkg::RSV_END_W-1:0]   rsv_end_reg;

    logic [pfra_pkg::FUNC_W-1:0]   func_reg;
    logic [pfra_pkg::FRAME_W-1:0]  idx_reg;
    pfra_pkg::row_t                ptr_reg;
    logic                          issue_done_reg;
    logic                          chk_vld_reg;
    pfra_pkg::row_t                chk_row_reg;

    logic [pfra_pkg::FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic [pfra_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          res_shared_reg, res_shared_next;

    logic                          m_valid_reg;
    logic [pfra_pkg::FRAME_W-1:0]  m_frame_reg;
    logic [pfra_pkg::STATUS_W-1:0] m_status_reg;
    logic                          m_shared_reg;

    pfra_pkg::frame_addr_t in_fa;
    pfra_pkg::frame_addr_t idx_fa;
    pfra_pkg::lane_t       idx_lane;
    logic                  idx_valid;
    pfra_pkg::cnt_t        cnt;
    pfra_pkg::cnt_t        cnt_new;
    logic                  rmw_we;
    logic [pfra_pkg::STATUS_W-1:0] rmw_status;
    logic                  rmw_shared;
    pfra_pkg::row_data_t   rmw_row;

    logic                  found_any;
    pfra_pkg::lane_t       found_lane;
    logic                  scan_hit;
    logic                  scan_oom;
    pfra_pkg::row_data_t   scan_row;

    logic [31:0]           sw_lo;
    logic [31:0]           sw_hi;
    logic [31:0]           sw_frame;
    pfra_pkg::row_data_t   sweep_row;

    // -------- config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsv_first_reg <= pfra_pkg::RSV_FIRST_RST;
            rsv_end_reg   <= pfra_pkg::RSV_END_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx)
                pfra_pkg::CFG_RSV_FIRST: rsv_first_reg <= cfg_wr_data[pfra_pkg::RSV_FIRST_W-1:0];
                pfra_pkg::CFG_RSV_END:   rsv_end_reg   <= cfg_wr_data[pfra_pkg::RSV_END_W-1:0];
                default: ;
            endcase
        end
    end

    // -------- frame address decode
    assign in_fa     = pfra_pkg::frame_addr_t'(s_frame_index);
    assign idx_fa    = pfra_pkg::frame_addr_t'(idx_reg);
    assign idx_lane  = idx_fa[pfra_pkg::LANE_W-1:0];
    assign idx_valid = 32'(idx_reg) < 32'(pfra_pkg::NUM_FRAMES);

    // -------- free / share / query evaluation
    always_comb begin
        cnt        = idx_valid ?
                     ram_rd_data[idx_lane*pfra_pkg::COUNT_BITS +: pfra_pkg::COUNT_BITS] : '0;
        cnt_new    = cnt;
        rmw_we     = 1'b0;
        rmw_status = pfra_pkg::ST_OK;
        rmw_shared = 1'b0;
        case (func_reg)
            pfra_pkg::FUNC_FREE: begin
                if (cnt == '0) begin
                    rmw_status = pfra_pkg::ST_FREE_FREE;
                end else begin
                    cnt_new = cnt - pfra_pkg::cnt_t'(1);
                    rmw_we  = 1'b1;
                end
            end
            pfra_pkg::FUNC_SHARE: begin
                if (cnt == '0) begin
                    rmw_status = pfra_pkg::ST_SHARE_FREE;
                end else if (cnt == pfra_pkg::CNT_MAX) begin
                    rmw_status = pfra_pkg::ST_SATURATED;
                end else begin
                    cnt_new = cnt + pfra_pkg::cnt_t'(1);
                    rmw_we  = 1'b1;
                end
            end
            pfra_pkg::FUNC_QUERY: begin
                rmw_shared = cnt > pfra_pkg::cnt_t'(1);
            end
            default: ;
        endcase
        rmw_row = ram_rd_data;
        rmw_row[idx_lane*pfra_pkg::COUNT_BITS +: pfra_pkg::COUNT_BITS] = cnt_new;
    end

    // -------- allocate scan: highest zero lane of the row just read
    always_comb begin
        found_any  = 1'b0;
        found_lane = '0;
        for (int l = 0; l < pfra_pkg::LANES; l++) begin
            if (ram_rd_data[l*pfra_pkg::COUNT_BITS +: pfra_pkg::COUNT_BITS] == '0) begin
                found_any  = 1'b1;
                found_lane = pfra_pkg::lane_t'(l);
            end
        end
        scan_row = ram_rd_data;
        scan_row[found_lane*pfra_pkg::COUNT_BITS +: pfra_pkg::COUNT_BITS] = pfra_pkg::cnt_t'(1);
    end

    assign scan_hit = cmd.scan_step && chk_vld_reg && found_any;
    assign scan_oom = cmd.scan_step && chk_vld_reg && !found_any && (chk_row_reg == '0);

    // -------- initialize pattern for the row under the sweep pointer
    always_comb begin
        sw_lo    = cmd.sweep_rst ? 32'(pfra_pkg::RSV_FIRST_RST) : 32'(rsv_first_reg);
        sw_hi    = cmd.sweep_rst ? 32'(pfra_pkg::RSV_END_RST)   : 32'(rsv_end_reg);
        sw_frame = '0;
        for (int l = 0; l < pfra_pkg::LANES; l++) begin
            sw_frame = 32'({ptr_reg, pfra_pkg::lane_t'(l)});
            sweep_row[l*pfra_pkg::COUNT_BITS +: pfra_pkg::COUNT_BITS] =
                ((sw_frame >= sw_lo) && (sw_frame < sw_hi)) ? pfra_pkg::cnt_t'(1) : '0;
        end
    end

    // -------- store port muxing
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg;
        if (cmd.accept) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = in_fa[pfra_pkg::FA_W-1:pfra_pkg::LANE_W];
        end else if (cmd.scan_step && !issue_done_reg) begin
            ram_rd_en = 1'b1;
        end

        ram_wr_en   = 1'b0;
        ram_wr_addr = ptr_reg;
        ram_wr_data = sweep_row;
        if (cmd.sweep_step) begin
            ram_wr_en = 1'b1;
        end else if (cmd.rmw_eval) begin
            ram_wr_en   = rmw_we && idx_valid;
            ram_wr_addr = idx_fa[pfra_pkg::FA_W-1:pfra_pkg::LANE_W];
            ram_wr_data = rmw_row;
        end else if (scan_hit) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = chk_row_reg;
            ram_wr_data = scan_row;
        end
    end

    // -------- pointers and scan pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                ptr_reg        <= pfra_pkg::row_t'(pfra_pkg::ROWS - 1);
                issue_done_reg <= 1'b0;
                chk_vld_reg    <= 1'b0;
            end else if (cmd.scan_step) begin
                ptr_reg        <= ptr_reg - pfra_pkg::row_t'(1);
                issue_done_reg <= issue_done_reg || (ptr_reg == '0);
                chk_vld_reg    <= !issue_done_reg;
            end else if (cmd.sweep_start) begin
                ptr_reg <= '0;
            end else if (cmd.sweep_step) begin
                ptr_reg <= ptr_reg + pfra_pkg::row_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            chk_row_reg <= ptr_reg;
        end
        if (cmd.accept) begin
            func_reg <= s_func;
            idx_reg  <= s_frame_index;
        end
    end

    // -------- pending result
    always_comb begin
        res_frame_next  = res_frame_reg;
        res_status_next = res_status_reg;
        res_shared_next = res_shared_reg;
        if (cmd.accept) begin
            res_frame_next  = s_frame_index;
            res_status_next = pfra_pkg::ST_OK;
            res_shared_next = 1'b0;
        end else if (cmd.rmw_eval) begin
            res_status_next = rmw_status;
            res_shared_next = rmw_shared;
        end else if (scan_hit) begin
            res_frame_next  = pfra_pkg::FRAME_W'({chk_row_reg, found_lane});
            res_status_next = pfra_pkg::ST_OK;
        end else if (scan_oom) begin
            res_frame_next  = '0;
            res_status_next = pfra_pkg::ST_OOM;
        end
    end

    always_ff @(posedge aclk) begin
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        res_shared_reg <= res_shared_next;
    end

    // -------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_frame_reg  <= res_frame_reg;
            m_status_reg <= res_status_reg;
            m_shared_reg <= res_shared_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_frame = m_frame_reg;
    assign m_status       = m_status_reg;
    assign m_is_shared    = m_shared_reg;

    assign sts.scan_done  = scan_hit || scan_oom;
    assign sts.sweep_last = (ptr_reg == pfra_pkg::row_t'(pfra_pkg::ROWS - 1));
    assign sts.out_busy   = m_valid_reg && !m_ready;

endmodule

// ===== rtl/page_frame_refcount_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator_top
// Per-frame reference counts with allocate / free / share / query / init.
// ----------------------------------------------------------------------------
// One item is in work at a time; each gives exactly one result transfer.
// Counts live in a simple dual-port RAM (one write port, one registered read
// port) of 2048 rows x 16 counts (8 bits each); every item cost comes from
// how many rows it has to touch there:
//   free, share, query : row read, row write-back, output load
//   unused codes       : accept, output load
//   allocate : scan goes one row (16 frames) per cycle from the top row down,
//              stopping at the first row with a free frame, or after row zero
//              with out of memory when the store is full
//   initialize : one row of the init pattern written per cycle
// After reset the block runs a clearing pass that loads the default reserved
// range (frames 512..767 at one) with s_ready low; configuration writes are
// taken during that pass. The output register lets the next item be accepted
// while the previous result waits for m_ready.
// ----------------------------------------------------------------------------
module page_frame_refcount_allocator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [pfra_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [pfra_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pfra_pkg::FUNC_W-1:0]     s_func,
    input  logic [pfra_pkg::FRAME_W-1:0]    s_frame_index,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pfra_pkg::FRAME_W-1:0]    m_result_frame,
    output logic [pfra_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_is_shared
);

    pfra_pkg::cmd_t      cmd;
    pfra_pkg::sts_t      sts;

    // count store port wiring
    logic                ram_wr_en;
    pfra_pkg::row_t      ram_wr_addr;
    pfra_pkg::row_data_t ram_wr_data;
    logic                ram_rd_en;
    pfra_pkg::row_t      ram_rd_addr;
    pfra_pkg::row_data_t ram_rd_data;

    // sequencer: decides which datapath op runs each cycle
    pfra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: item regs, row evaluate, scan/sweep pointers, output reg
    pfra_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_idx        (cfg_idx),
        .cfg_wr_data    (cfg_wr_data),
        .s_func         (s_func),
        .s_frame_index  (s_frame_index),
        .cmd            (cmd),
        .sts            (sts),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_frame (m_result_frame),
        .m_status       (m_status),
        .m_is_shared    (m_is_shared)
    );

    // count store: one row = LANES counts
    pfra_ram #(
        .WIDTH (pfra_pkg::ROW_DATA_W),
        .DEPTH (pfra_pkg::ROWS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== rtl/pfra_checker.sv =====
// ----------------------------------------------------------------------------
// pfra_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfra_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [pfra_pkg::FRAME_W-1:0]  m_result_frame,
    input logic [pfra_pkg::STATUS_W-1:0] m_status,
    input logic                          m_is_shared
);

    // clearing pass follows reset: no request taken right after it
    a_no_ready_after_rst: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_frame)
                                && $stable(m_status) && $stable(m_is_shared))
        else $error("result changed while stalled");

    // out of memory returns frame zero and no shared flag
    a_oom_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == pfra_pkg::ST_OOM) |-> (m_result_frame == '0) && !m_is_shared)
        else $error("out of memory result carries a frame");

    // shared flag only comes with an ok status
    a_shared_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_shared |-> (m_status == pfra_pkg::ST_OK))
        else $error("shared flag with error status");

    // status stays within defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= pfra_pkg::ST_SATURATED))
        else $error("undefined status code");

endmodule

bind page_frame_refcount_allocator_top pfra_checker u_pfra_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_frame (m_result_frame),
    .m_status       (m_status),
    .m_is_shared    (m_is_shared)
);

// ===== tb/page_frame_refcount_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator_top_tb
// Self-checking bench for the page frame reference count allocator. A local
// copy of the count store predicts every reply at request acceptance. Replies
// are checked in order against those predictions, while both channels stall
// at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_refcount_allocator_top_tb;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 20000;  // well above a full scan or sweep
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int HELD_MAX       = 64;

    // Selector values with no operation behind them
    localparam logic [pfra_pkg::FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [pfra_pkg::FUNC_W-1:0] FUNC_SPARE_MID   = 3'd6;
    localparam logic [pfra_pkg::FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [pfra_pkg::FRAME_W-1:0]  frame;
        logic [pfra_pkg::STATUS_W-1:0] status;
        logic                          shared;
    } frame_reply_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                            aclk          = 1'b0;
    logic                            aresetn       = 1'b0;
    logic                            cfg_wr_en     = 1'b0;
    logic [pfra_pkg::CFG_IDX_W-1:0]  cfg_idx       = pfra_pkg::CFG_RSV_FIRST;
    logic [pfra_pkg::CFG_DATA_W-1:0] cfg_wr_data   = '0;
    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic [pfra_pkg::FUNC_W-1:0]     s_func        = pfra_pkg::FUNC_QUERY;
    logic [pfra_pkg::FRAME_W-1:0]    s_frame_index = '0;
    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic [pfra_pkg::FRAME_W-1:0]    m_result_frame;
    logic [pfra_pkg::STATUS_W-1:0]   m_status;
    logic                            m_is_shared;

    page_frame_refcount_allocator_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_idx        (cfg_idx),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_frame_index  (s_frame_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_frame (m_result_frame),
        .m_status       (m_status),
        .m_is_shared    (m_is_shared)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predicted state: one count per frame plus the reserved range registers.
    // The clearing pass after reset always loads the reset range, so the
    // store starts from that pattern whatever gets written during the pass.
    // ------------------------------------------------------------------------
    pfra_pkg::cnt_t                   frame_cnt [pfra_pkg::NUM_FRAMES];
    logic [pfra_pkg::RSV_FIRST_W-1:0] rsv_first;
    logic [pfra_pkg::RSV_END_W-1:0]   rsv_end;

    frame_reply_t                 replies_due [$];   // predicted replies, oldest first
    logic [pfra_pkg::FRAME_W-1:0] held_frames [$];   // frames handed out by allocate
    frame_reply_t                 want_reply;

    bit no_idle = 1'b0;    // set for stretches with back-to-back transfers
    int hold_left = 0;
    int stall_cycles = 0;

    int err_count   = 0;
    int n_checked   = 0;
    int n_requests  = 0;
    int n_allocs    = 0;
    int n_inits     = 0;
    int n_oom       = 0;
    int n_saturated = 0;
    int n_free_hits = 0;   // free or share aimed at a free frame
    int n_shared    = 0;

    // Initialize: clear everything, then ones over the reserved range clipped
    // to the store; an empty or inverted range leaves the store all zero.
    function automatic void load_reserved_pattern();
        int unsigned hi;
        hi = (rsv_end > pfra_pkg::NUM_FRAMES) ? pfra_pkg::NUM_FRAMES : rsv_end;
        foreach (frame_cnt[k])
            frame_cnt[k] = (k >= rsv_first && k < hi) ? pfra_pkg::cnt_t'(1) : '0;
    endfunction

    // Applies one request to the predicted store and returns its reply.
    function automatic frame_reply_t apply_frame_op(
            input logic [pfra_pkg::FUNC_W-1:0]  func,
            input logic [pfra_pkg::FRAME_W-1:0] idx);
        frame_reply_t   r;
        pfra_pkg::cnt_t cnt;
        cnt      = frame_cnt[idx];
        r.frame  = idx;
        r.status = pfra_pkg::ST_OK;
        r.shared = 1'b0;
        case (func)
            pfra_pkg::FUNC_ALLOC: begin
                // top-down search for the first free frame
                r.frame  = '0;
                r.status = pfra_pkg::ST_OOM;
                for (int k = pfra_pkg::NUM_FRAMES - 1; k >= 0; k--) begin
                    if (frame_cnt[k] == '0) begin
                        frame_cnt[k] = pfra_pkg::cnt_t'(1);
                        r.frame      = pfra_pkg::FRAME_W'(k);
                        r.status     = pfra_pkg::ST_OK;
                        break;
                    end
                end
            end
            pfra_pkg::FUNC_FREE: begin
                if (cnt == '0)
                    r.status = pfra_pkg::ST_FREE_FREE;
                else
                    frame_cnt[idx] = cnt - 1'b1;
            end
            pfra_pkg::FUNC_SHARE: begin
                if (cnt == '0)
                    r.status = pfra_pkg::ST_SHARE_FREE;
                else if (cnt == pfra_pkg::CNT_MAX)
                    r.status = pfra_pkg::ST_SATURATED;
                else
                    frame_cnt[idx] = cnt + 1'b1;
            end
            pfra_pkg::FUNC_QUERY: r.shared = (cnt > pfra_pkg::cnt_t'(1));
            pfra_pkg::FUNC_INIT:  load_reserved_pattern();
            default: ;
        endcase
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Frame mix: half frames that were handed out, some at the reserved
    // range edges, the rest anywhere.
    function automatic logic [pfra_pkg::FRAME_W-1:0] pick_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && held_frames.size() != 0)
            return held_frames[$urandom_range(0, held_frames.size() - 1)];
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0:       return pfra_pkg::FRAME_W'(rsv_first - 1'b1);
                1:       return rsv_first;
                2:       return pfra_pkg::FRAME_W'(rsv_end - 1'b1);
                default: return pfra_pkg::FRAME_W'(rsv_end);
            endcase
        end
        return pfra_pkg::FRAME_W'($urandom);
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Configuration writes: both registers back to back, predictor follows.
    // Called with the block idle or during the clearing pass.
    // ------------------------------------------------------------------------
    task automatic set_reserved(input logic [pfra_pkg::CFG_DATA_W-1:0] first_data,
                                input logic [pfra_pkg::CFG_DATA_W-1:0] end_data);
        cfg_wr_en   <= 1'b1;
        cfg_idx     <= pfra_pkg::CFG_RSV_FIRST;
        cfg_wr_data <= first_data;
        @(posedge aclk);
        cfg_idx     <= pfra_pkg::CFG_RSV_END;
        cfg_wr_data <= end_data;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        rsv_first = first_data[pfra_pkg::RSV_FIRST_W-1:0];   // upper bit is dropped
        rsv_end   = end_data;
    endtask

    // ------------------------------------------------------------------------
    // One request transfer. Valid stays high after acceptance so that a
    // zero-gap follow-up rides straight on; whoever idles the channel next
    // lowers it. The reply is predicted at the accepting edge.
    // ------------------------------------------------------------------------
    task automatic issue_request(input logic [pfra_pkg::FUNC_W-1:0]  func,
                                 input logic [pfra_pkg::FRAME_W-1:0] idx,
                                 output frame_reply_t                reply);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_frame_index <= idx;
        do @(posedge aclk); while (!s_ready);
        reply = apply_frame_op(func, idx);
        replies_due.push_back(reply);
        n_requests++;
        if (func == pfra_pkg::FUNC_ALLOC)
            n_allocs++;
        if (func == pfra_pkg::FUNC_INIT)
            n_inits++;
        if (reply.shared)
            n_shared++;
        case (reply.status)
            pfra_pkg::ST_OOM:        n_oom++;
            pfra_pkg::ST_SATURATED:  n_saturated++;
            pfra_pkg::ST_FREE_FREE,
            pfra_pkg::ST_SHARE_FREE: n_free_hits++;
            default: ;
        endcase
        if (func == pfra_pkg::FUNC_ALLOC && reply.status == pfra_pkg::ST_OK) begin
            held_frames.push_back(reply.frame);
            if (held_frames.size() > HELD_MAX)
                void'(held_frames.pop_front());
        end
    endtask

    // Drop valid and hold off until every predicted reply is back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random m_ready stalls, in-order check of every transfer.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t ns: reply transfer with nothing expected: frame %0d status %0d",
                         $time, m_result_frame, m_status);
                err_count++;
            end else begin
                want_reply = replies_due.pop_front();
                compare_field("result_frame", want_reply.frame, m_result_frame);
                compare_field("status", want_reply.status, m_status);
                compare_field("is_shared", want_reply.shared, m_is_shared);
                n_checked++;
            end
        end
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready   <= 1'b1;
            hold_left <= pick_gap();
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d replies outstanding",
                     $time, stall_cycles, replies_due.size());
            $display("page_frame_refcount_allocator_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed: every operation once or more, the unused selectors, free and
    // share of a free frame, query of shared and unshared frames, re-init.
    // The first config write lands during the clearing pass.
    // ------------------------------------------------------------------------
    task automatic test_directed_ops();
        frame_reply_t r;
        logic [pfra_pkg::FRAME_W-1:0] top;
        set_reserved(pfra_pkg::RSV_FIRST_RST, pfra_pkg::RSV_END_RST);
        issue_request(pfra_pkg::FUNC_QUERY, 15'd512, r);     // reserved, count one
        issue_request(pfra_pkg::FUNC_QUERY, 15'd511, r);     // just below, free
        issue_request(pfra_pkg::FUNC_ALLOC, pfra_pkg::FRAME_W'($urandom), r);
        top = r.frame;
        issue_request(pfra_pkg::FUNC_SHARE, top, r);
        issue_request(pfra_pkg::FUNC_QUERY, top, r);         // count two: shared
        issue_request(pfra_pkg::FUNC_FREE, top, r);
        issue_request(pfra_pkg::FUNC_FREE, top, r);          // back to zero
        issue_request(pfra_pkg::FUNC_FREE, top, r);          // free of a free frame
        issue_request(pfra_pkg::FUNC_SHARE, top, r);         // share of a free frame
        issue_request(pfra_pkg::FUNC_QUERY, '0, r);
        issue_request(pfra_pkg::FUNC_FREE, '0, r);
        issue_request(pfra_pkg::FUNC_FREE, 15'd767, r);      // last reserved frame
        issue_request(pfra_pkg::FUNC_ALLOC, '1, r);
        issue_request(pfra_pkg::FUNC_ALLOC, '0, r);
        issue_request(FUNC_SPARE_FIRST, '1, r);
        issue_request(FUNC_SPARE_MID, '0, r);
        issue_request(FUNC_SPARE_LAST, 15'h5555, r);
        issue_request(pfra_pkg::FUNC_QUERY, '1, r);
        issue_request(pfra_pkg::FUNC_INIT, 15'h2AAA, r);
        issue_request(pfra_pkg::FUNC_QUERY, 15'd767, r);
        issue_request(pfra_pkg::FUNC_ALLOC, pfra_pkg::FRAME_W'($urandom), r);
    endtask

    // ------------------------------------------------------------------------
    // Reserved range extremes: whole store (out of memory), inverted range,
    // single top frame, end beyond the store (clipped), empty range.
    // ------------------------------------------------------------------------
    task automatic test_reserved_range_extremes();
        frame_reply_t r;
        wait_drained();
        set_reserved('0, 16'h8000);
        issue_request(pfra_pkg::FUNC_INIT, '0, r);
        issue_request(pfra_pkg::FUNC_ALLOC, pfra_pkg::FRAME_W'($urandom), r);  // store full
        issue_request(pfra_pkg::FUNC_QUERY, '0, r);
        issue_request(pfra_pkg::FUNC_FREE, 15'd16384, r);
        issue_request(pfra_pkg::FUNC_ALLOC, '0, r);           // finds the hole
        issue_request(pfra_pkg::FUNC_ALLOC, '1, r);           // full again

        wait_drained();
        set_reserved(16'hFFFF, '0);                           // first above end
        issue_request(pfra_pkg::FUNC_INIT, '1, r);
        issue_request(pfra_pkg::FUNC_QUERY, 15'd512, r);
        issue_request(pfra_pkg::FUNC_ALLOC, '0, r);

        wait_drained();
        set_reserved(16'h7FFF, 16'h8000);                     // only the top frame
        issue_request(pfra_pkg::FUNC_INIT, '0, r);
        issue_request(pfra_pkg::FUNC_ALLOC, '0, r);
        issue_request(pfra_pkg::FUNC_SHARE, '1, r);
        issue_request(pfra_pkg::FUNC_QUERY, '1, r);

        wait_drained();
        set_reserved(16'd100, 16'hFFFF);                      // clipped at the top
        issue_request(pfra_pkg::FUNC_INIT, '0, r);
        issue_request(pfra_pkg::FUNC_ALLOC, '0, r);           // scans from the top down to row 6
        issue_request(pfra_pkg::FUNC_FREE, 15'd100, r);
        issue_request(pfra_pkg::FUNC_ALLOC, '0, r);

        wait_drained();
        set_reserved(16'd5, 16'd5);                           // empty range
        issue_request(pfra_pkg::FUNC_INIT, '0, r);
        issue_request(pfra_pkg::FUNC_QUERY, 15'd5, r);
    endtask

    // ------------------------------------------------------------------------
    // Count saturation: push one frame past the count maximum, then step it
    // back down and up again. First half back to back, second half stalled.
    // ------------------------------------------------------------------------
    task automatic test_share_saturation();
        frame_reply_t r;
        logic [pfra_pkg::FRAME_W-1:0] victim;
        wait_drained();
        set_reserved(pfra_pkg::RSV_FIRST_RST, pfra_pkg::RSV_END_RST);
        issue_request(pfra_pkg::FUNC_INIT, pfra_pkg::FRAME_W'($urandom), r);
        issue_request(pfra_pkg::FUNC_ALLOC, pfra_pkg::FRAME_W'($urandom), r);
        victim  = r.frame;
        no_idle = 1'b1;
        for (int i = 0; i < 290; i++) begin
            if (i == 145)
                no_idle = 1'b0;
            issue_request((i % 32 == 31) ? pfra_pkg::FUNC_QUERY : pfra_pkg::FUNC_SHARE,
                          victim, r);
        end
        issue_request(pfra_pkg::FUNC_FREE, victim, r);
        issue_request(pfra_pkg::FUNC_SHARE, victim, r);
        issue_request(pfra_pkg::FUNC_SHARE, victim, r);       // saturated again
        issue_request(pfra_pkg::FUNC_QUERY, victim, r);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic in phases. Each phase drains the block (sender held off
    // until every reply is back), picks a new reserved range and initializes.
    // Allocations feed the frame pool, so half of the free/share/query requests
    // aim at allocated frames, some of them stale; the rest is range edges and noise.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        frame_reply_t r;
        logic [pfra_pkg::FUNC_W-1:0] func;
        int unsigned lo;
        int unsigned hi;
        int pick;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin
                    lo = $urandom_range(0, 32767);
                    hi = lo + $urandom_range(1, 2048);
                end
                1: begin
                    lo = $urandom_range(0, 32767);
                    hi = $urandom_range(0, lo);
                end
                2: begin
                    lo = pfra_pkg::RSV_FIRST_RST;
                    hi = pfra_pkg::RSV_END_RST;
                end
                default: begin
                    lo = $urandom_range(28000, 32767);
                    hi = pfra_pkg::NUM_FRAMES;
                end
            endcase
            // bit 15 of the first-frame write is noise the register drops
            set_reserved(pfra_pkg::CFG_DATA_W'(lo)
                             | (pfra_pkg::CFG_DATA_W'($urandom_range(0, 1)) << 15),
                         pfra_pkg::CFG_DATA_W'(hi));
            held_frames.delete();
            issue_request(pfra_pkg::FUNC_INIT, pfra_pkg::FRAME_W'($urandom), r);
            no_idle = (phase % 3 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 22)
                    func = pfra_pkg::FUNC_ALLOC;
                else if (pick < 45)
                    func = pfra_pkg::FUNC_FREE;
                else if (pick < 66)
                    func = pfra_pkg::FUNC_SHARE;
                else if (pick < 90)
                    func = pfra_pkg::FUNC_QUERY;
                else if (pick < 91)
                    func = pfra_pkg::FUNC_INIT;
                else
                    func = pfra_pkg::FUNC_W'($urandom_range(FUNC_SPARE_FIRST,
                                                            FUNC_SPARE_LAST));
                issue_request(func, pick_frame(), r);
            end
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rsv_first = pfra_pkg::RSV_FIRST_RST;
        rsv_end   = pfra_pkg::RSV_END_RST;
        load_reserved_pattern();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_ops();
        test_reserved_range_extremes();
        test_share_saturation();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d requests (%0d allocate, %0d initialize) and checked %0d replies.",
                 n_requests, n_allocs, n_inits, n_checked);
        $display("Seen: %0d out of memory, %0d saturated, %0d free-frame hits, %0d shared.",
                 n_oom, n_saturated, n_free_hits, n_shared);
        if (err_count == 0)
            $display("page_frame_refcount_allocator_top regression: pass");
        else
            $display("page_frame_refcount_allocator_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pfra_pkg.sv
rtl/pfra_ram.sv
rtl/pfra_ctrl.sv
rtl/pfra_datapath.sv
rtl/page_frame_refcount_allocator_top.sv
rtl/pfra_checker.sv
tb/page_frame_refcount_allocator_top_tb.sv
